### rtl/core/ufa_pkg.sv
// ufa_pkg: shared types, constants and the arctangent table for the
// angle-to-unit-axis block. No dependencies.
`timescale 1ns / 1ps

package ufa_pkg;

    // Inverse CORDIC gain scaled to Q1.30
    localparam logic signed [33:0] GAIN_START = 34'sd652032874;
    localparam logic [29:0] HALF_QUADRANT = 30'h2000_0000;
    localparam logic [30:0] QUADRANT      = 31'h4000_0000;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Rotated vector handed from the CORDIC unit to the normalizer
    typedef struct packed {
        logic signed [33:0] px;
        logic signed [33:0] py;
        logic [1:0]         quad;
        logic               cardinal;
    } ufa_vec_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_DONE
    } ufa_cstate_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQX,
        N_SQY,
        N_SHIFT,
        N_ROOT,
        N_DSET,
        N_DIV,
        N_DONE
    } ufa_nstate_t;

    // Arctangent of 2^-i in turns, 2^32 is one revolution
    function automatic logic [29:0] ufa_atan(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'h2000_0000;
            5'd1:  v = 30'h12E4_051E;
            5'd2:  v = 30'h09FB_385B;
            5'd3:  v = 30'h0511_11D4;
            5'd4:  v = 30'h028B_0D43;
            5'd5:  v = 30'h0145_D7E1;
            5'd6:  v = 30'h00A2_F61E;
            5'd7:  v = 30'h0051_7C55;
            5'd8:  v = 30'h0028_BE53;
            5'd9:  v = 30'h0014_5F2F;
            5'd10: v = 30'h000A_2F98;
            5'd11: v = 30'h0005_17CC;
            5'd12: v = 30'h0002_8BE6;
            5'd13: v = 30'h0001_45F3;
            5'd14: v = 30'h0000_A2FA;
            5'd15: v = 30'h0000_517D;
            5'd16: v = 30'h0000_28BE;
            5'd17: v = 30'h0000_145F;
            5'd18: v = 30'h0000_0A30;
            5'd19: v = 30'h0000_0518;
            5'd20: v = 30'h0000_028C;
            5'd21: v = 30'h0000_0146;
            5'd22: v = 30'h0000_00A3;
            5'd23: v = 30'h0000_0051;
            5'd24: v = 30'h0000_0029;
            5'd25: v = 30'h0000_0014;
            5'd26: v = 30'h0000_000A;
            5'd27: v = 30'h0000_0005;
            5'd28: v = 30'h0000_0003;
            5'd29: v = 30'h0000_0001;
            5'd30: v = 30'h0000_0001;
            default: v = 30'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/unit_axis_from_angle.sv
// unit_axis_from_angle: top level, turn angle to Q1.30 unit vector.
// Depends on ufa_pkg, ufa_cordic and ufa_norm.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------
//   input   | in_valid / in_stall | angle [31:0] unsigned turns
//   output  | out_valid/out_stall | axis_x, axis_y [31:0] signed Q1.30
//
// An angle passes through the CORDIC steps, pre-shift steps of the squared length
// where needed, 32 root steps and two long divisions before its result enters
// the output register; the CORDIC unit and the normalizer each run their own
// sequencer. Cardinal angles skip the rotation, the root and the divisions.
// in_stall is high from an input transfer until its result enters the
// output register; a result waiting there does not block the next angle.
// Reset clears the control state only.
`timescale 1ns / 1ps

module unit_axis_from_angle #(
    parameter int ROTATION_STEPS = 31,
    parameter int FRACTION_BITS  = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] axis_x,
    output logic signed [31:0] axis_y
);
    import ufa_pkg::*;

    logic        busy_reg;
    logic        out_valid_reg;
    logic [31:0] axis_x_reg, axis_y_reg;

    logic        in_xfer;
    logic        vec_valid;
    ufa_vec_t    vec;
    logic        result_valid;
    logic        load;
    logic [31:0] res_x, res_y;

    assign in_stall = busy_reg;
    assign in_xfer  = in_valid && !busy_reg;
    assign load     = result_valid && (!out_valid_reg || !out_stall);

    ufa_cordic #(
        .ROTATION_STEPS(ROTATION_STEPS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .angle    (angle),
        .vec_valid(vec_valid),
        .vec      (vec)
    );

    ufa_norm #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_norm (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (vec_valid),
        .vec         (vec),
        .result_valid(result_valid),
        .ack         (load),
        .res_x       (res_x),
        .res_y       (res_y)
    );

    // Busy flag and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                busy_reg <= 1'b1;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            axis_x_reg <= res_x;
            axis_y_reg <= res_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign axis_x    = $signed(axis_x_reg);
    assign axis_y    = $signed(axis_y_reg);

endmodule

### rtl/core/ufa_cordic.sv
// ufa_cordic: octant fold and iterative CORDIC rotation, one step a cycle
// through a shared shift/add unit. Depends on ufa_pkg.
`timescale 1ns / 1ps

module ufa_cordic #(
    parameter int ROTATION_STEPS = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       angle,
    output logic              vec_valid,
    output ufa_pkg::ufa_vec_t vec
);
    import ufa_pkg::*;

    ufa_cstate_t state_reg, state_next;

    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [4:0]         i_reg;
    logic               swap_reg;
    logic [1:0]         quad_reg;
    logic               card_reg;

    logic [29:0]        phase;
    logic signed [33:0] dx, dy;
    logic signed [32:0] atan_ext;
    logic signed [33:0] c_val, s_val;
    logic               last_step;

    assign phase     = angle[29:0];
    assign dx        = x_reg >>> i_reg;
    assign dy        = y_reg >>> i_reg;
    assign atan_ext  = $signed({3'b000, ufa_atan(i_reg)});
    assign last_step = (i_reg == 5'(ROTATION_STEPS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = (phase == '0) ? C_DONE : C_RUN;
                end
            end
            C_RUN:
            begin
                if (last_step)
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        vec_valid = (state_reg == C_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Fold on start, one rotation step per cycle while running
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            quad_reg <= angle[31:30];
            card_reg <= (phase == '0);
            swap_reg <= (phase > HALF_QUADRANT);
            if (phase > HALF_QUADRANT)
            begin
                z_reg <= $signed({2'b00, QUADRANT - {1'b0, phase}});
            end
            else
            begin
                z_reg <= $signed({3'b000, phase});
            end
            x_reg <= GAIN_START;
            y_reg <= '0;
            i_reg <= '0;
        end
        else if (state_reg == C_RUN)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - dy;
                y_reg <= y_reg + dx;
                z_reg <= z_reg - atan_ext;
            end
            else
            begin
                x_reg <= x_reg + dy;
                y_reg <= y_reg - dx;
                z_reg <= z_reg + atan_ext;
            end
            i_reg <= i_reg + 5'd1;
        end
    end

    // Undo the half-quadrant swap and rotate back to the quadrant
    assign c_val = swap_reg ? y_reg : x_reg;
    assign s_val = swap_reg ? x_reg : y_reg;

    always_comb
    begin
        vec.quad     = quad_reg;
        vec.cardinal = card_reg;
        unique case (quad_reg)
            QUAD_0:
            begin
                vec.px = c_val;
                vec.py = s_val;
            end
            QUAD_1:
            begin
                vec.px = -s_val;
                vec.py = c_val;
            end
            QUAD_2:
            begin
                vec.px = -c_val;
                vec.py = -s_val;
            end
            default:
            begin
                vec.px = s_val;
                vec.py = -c_val;
            end
        endcase
    end

endmodule

### rtl/core/ufa_norm.sv
// ufa_norm: exact renormalization: squared length through one shared
// multiplier, even pre-shift, bit-serial root, restoring division.
// Depends on ufa_pkg.
`timescale 1ns / 1ps

module ufa_norm #(
    parameter int FRACTION_BITS = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ufa_pkg::ufa_vec_t vec,
    output logic              result_valid,
    input  logic              ack,
    output logic [31:0]       res_x,
    output logic [31:0]       res_y
);
    import ufa_pkg::*;

    localparam logic [31:0] ONE = 32'(1) << FRACTION_BITS;

    ufa_nstate_t state_reg, state_next;

    logic [63:0] magx_reg, magy_reg;
    logic        negx_reg, negy_reg;
    logic [1:0]  quad_reg;
    logic        card_reg;
    logic [63:0] len_reg;
    logic [63:0] rv_reg, root_reg, bit_reg;
    logic [63:0] r_reg;
    logic [31:0] acc_reg;
    logic        sat_reg;
    logic        comp_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] x_reg, y_reg;

    logic [31:0] abs_px, abs_py;
    logic [31:0] mul_a;
    logic [63:0] product;
    logic [63:0] trial;
    logic [63:0] r_shift;
    logic        r_ge;
    logic [31:0] acc_next;
    logic [31:0] q_val;
    logic [31:0] fb_x, fb_y;
    logic        div_last;

    assign abs_px = vec.px[33] ? 32'(-vec.px) : 32'(vec.px);
    assign abs_py = vec.py[33] ? 32'(-vec.py) : 32'(vec.py);

    // Shared squarer
    assign mul_a   = (state_reg == N_SQX) ? magx_reg[31:0] : magy_reg[31:0];
    assign product = 64'(mul_a) * 64'(mul_a);

    // Root step and division step
    assign trial    = root_reg + bit_reg;
    assign r_shift  = r_reg << 1;
    assign r_ge     = (r_shift >= root_reg);
    assign acc_next = {acc_reg[30:0], r_ge};
    assign q_val    = sat_reg ? ONE : acc_next;
    assign div_last = (cnt_reg == 5'(FRACTION_BITS - 1));

    // Cardinal axis of the quadrant
    always_comb
    begin
        unique case (quad_reg)
            QUAD_0:
            begin
                fb_x = ONE;
                fb_y = '0;
            end
            QUAD_1:
            begin
                fb_x = '0;
                fb_y = ONE;
            end
            QUAD_2:
            begin
                fb_x = -ONE;
                fb_y = '0;
            end
            default:
            begin
                fb_x = '0;
                fb_y = -ONE;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = N_SQX;
                end
            end
            N_SQX:
            begin
                state_next = card_reg ? N_DONE : N_SQY;
            end
            N_SQY:  state_next = N_SHIFT;
            N_SHIFT:
            begin
                if (len_reg == '0)
                begin
                    state_next = N_DONE;
                end
                else if (len_reg[63:60] != 4'b0000)
                begin
                    state_next = N_ROOT;
                end
            end
            N_ROOT:
            begin
                if (bit_reg == 64'd1)
                begin
                    state_next = N_DSET;
                end
            end
            N_DSET: state_next = N_DIV;
            N_DIV:
            begin
                if (div_last)
                begin
                    state_next = comp_reg ? N_DONE : N_DSET;
                end
            end
            N_DONE:
            begin
                if (ack)
                begin
                    state_next = N_IDLE;
                end
            end
            default: state_next = N_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        result_valid = (state_reg == N_DONE);
        res_x        = x_reg;
        res_y        = y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    magx_reg <= 64'(abs_px);
                    magy_reg <= 64'(abs_py);
                    negx_reg <= vec.px[33];
                    negy_reg <= vec.py[33];
                    quad_reg <= vec.quad;
                    card_reg <= vec.cardinal;
                end
            end
            N_SQX:
            begin
                len_reg <= product;
                if (card_reg)
                begin
                    x_reg <= fb_x;
                    y_reg <= fb_y;
                end
            end
            N_SQY:
            begin
                len_reg <= len_reg + product;
            end
            N_SHIFT:
            begin
                if (len_reg == '0)
                begin
                    x_reg <= fb_x;
                    y_reg <= fb_y;
                end
                else if (len_reg[63:60] == 4'b0000)
                begin
                    len_reg  <= len_reg << 2;
                    magx_reg <= magx_reg << 1;
                    magy_reg <= magy_reg << 1;
                end
                else
                begin
                    rv_reg   <= len_reg;
                    root_reg <= '0;
                    bit_reg  <= 64'd1 << 62;
                end
            end
            N_ROOT:
            begin
                if (rv_reg >= trial)
                begin
                    rv_reg   <= rv_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                comp_reg <= 1'b0;
            end
            N_DSET:
            begin
                r_reg   <= comp_reg ? magy_reg : magx_reg;
                sat_reg <= comp_reg ? (magy_reg >= root_reg) : (magx_reg >= root_reg);
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            N_DIV:
            begin
                r_reg   <= r_ge ? (r_shift - root_reg) : r_shift;
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (div_last)
                begin
                    if (comp_reg)
                    begin
                        y_reg <= negy_reg ? -q_val : q_val;
                    end
                    else
                    begin
                        x_reg <= negx_reg ? -q_val : q_val;
                    end
                    comp_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
